// ===== rtl/core/pa_pkg.sv =====
// shared types and constants of the primitive assembler
// no dependencies; used by pa_decode, pa_emit and primitive_assembler
package pa_pkg;

	localparam int INDEX_WIDTH = 32;

	typedef logic [INDEX_WIDTH-1:0] idx_t;

	// primitive mode codes
	localparam logic [3:0] MODE_POINTS      = 4'd0;
	localparam logic [3:0] MODE_LINES       = 4'd1;
	localparam logic [3:0] MODE_LINE_STRIP  = 4'd2;
	localparam logic [3:0] MODE_LINE_LOOP   = 4'd3;
	localparam logic [3:0] MODE_TRIANGLES   = 4'd4;
	localparam logic [3:0] MODE_TRI_STRIP   = 4'd5;
	localparam logic [3:0] MODE_TRI_FAN     = 4'd6;
	localparam logic [3:0] MODE_POLYGON     = 4'd7;
	localparam logic [3:0] MODE_QUADS       = 4'd8;
	localparam logic [3:0] MODE_QUAD_STRIP  = 4'd9;

	// result kinds
	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_TRI   = 2'd2;

	// configuration register indexes
	localparam logic [3:0] CFG_PRIMITIVE_MODE     = 4'd0;
	localparam logic [3:0] CFG_TRIANGLES_AS_FACES = 4'd1;

	// per-set assembly state
	typedef struct packed {
		idx_t       first_index;
		idx_t       prev0;
		idx_t       prev1;
		logic [1:0] position;
		logic       strip_parity;
		logic       have_first;
	} set_state_t;

	// up to two primitives produced by one vertex
	typedef struct packed {
		logic [1:0] num_prims;
		logic [1:0] kind;
		logic       wireframe;
		idx_t       a0;
		idx_t       b0;
		idx_t       c0;
		idx_t       a1;
		idx_t       b1;
		idx_t       c1;
	} job_t;

endpackage

// ===== rtl/core/pa_decode.sv =====
// set state registers and per-vertex decode into a primitive job
// depends on pa_pkg
module pa_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        mode,
	input  logic              faces,
	input  pa_pkg::idx_t      v,
	input  logic              last,
	input  logic              consume,
	input  logic              clear,
	output pa_pkg::job_t      job
);

	pa_pkg::set_state_t st_q;
	pa_pkg::set_state_t st_d;

	always_comb begin
		st_d = st_q;
		job = '0;
		job.kind = pa_pkg::KIND_TRI;
		job.wireframe = !faces;
		case (mode)
			pa_pkg::MODE_POINTS: begin
				job.num_prims = 2'd1;
				job.kind = pa_pkg::KIND_POINT;
				job.wireframe = 1'b0;
				job.a0 = v;
			end
			pa_pkg::MODE_LINES: begin
				job.kind = pa_pkg::KIND_LINE;
				job.wireframe = 1'b0;
				if (st_q.position == 2'd0) begin
					st_d.prev0 = v;
					st_d.position = 2'd1;
				end else begin
					job.num_prims = 2'd1;
					job.a0 = st_q.prev0;
					job.b0 = v;
					st_d.position = 2'd0;
				end
			end
			pa_pkg::MODE_LINE_STRIP, pa_pkg::MODE_LINE_LOOP: begin
				job.kind = pa_pkg::KIND_LINE;
				job.wireframe = 1'b0;
				if (st_q.have_first) begin
					job.num_prims = 2'd1;
					job.a0 = st_q.prev0;
					job.b0 = v;
					// loop closes back to the first index
					if (mode == pa_pkg::MODE_LINE_LOOP && last) begin
						job.num_prims = 2'd2;
						job.a1 = v;
						job.b1 = st_q.first_index;
					end
				end else begin
					st_d.first_index = v;
				end
				st_d.prev0 = v;
			end
			pa_pkg::MODE_TRIANGLES: begin
				if (st_q.position == 2'd0) begin
					st_d.first_index = v;
					st_d.position = 2'd1;
				end else if (st_q.position == 2'd1) begin
					st_d.prev0 = v;
					st_d.position = 2'd2;
				end else begin
					job.num_prims = 2'd1;
					job.a0 = st_q.first_index;
					job.b0 = st_q.prev0;
					job.c0 = v;
					st_d.position = 2'd0;
				end
			end
			pa_pkg::MODE_TRI_STRIP: begin
				if (st_q.position >= 2'd2) begin
					job.num_prims = 2'd1;
					job.a0 = st_q.prev1;
					// odd strip vertices swap winding
					job.b0 = st_q.strip_parity ? v : st_q.prev0;
					job.c0 = st_q.strip_parity ? st_q.prev0 : v;
				end else begin
					st_d.position = st_q.position + 2'd1;
				end
				st_d.prev1 = st_q.prev0;
				st_d.prev0 = v;
				st_d.strip_parity = !st_q.strip_parity;
			end
			pa_pkg::MODE_TRI_FAN, pa_pkg::MODE_POLYGON: begin
				if (st_q.position == 2'd0) begin
					st_d.first_index = v;
					st_d.position = 2'd1;
				end else begin
					if (st_q.position >= 2'd2) begin
						job.num_prims = 2'd1;
						job.a0 = st_q.first_index;
						job.b0 = st_q.prev0;
						job.c0 = v;
					end else begin
						st_d.position = 2'd2;
					end
					st_d.prev0 = v;
				end
			end
			pa_pkg::MODE_QUADS, pa_pkg::MODE_QUAD_STRIP: begin
				if (st_q.position == 2'd0) begin
					st_d.first_index = v;
					st_d.position = 2'd1;
				end else if (st_q.position == 2'd1) begin
					st_d.prev1 = v;
					st_d.position = 2'd2;
				end else if (st_q.position == 2'd2) begin
					st_d.prev0 = v;
					st_d.position = 2'd3;
				end else begin
					job.num_prims = 2'd2;
					job.a0 = st_q.first_index;
					job.b0 = st_q.prev1;
					job.c0 = st_q.prev0;
					if (mode == pa_pkg::MODE_QUADS) begin
						job.a1 = st_q.first_index;
						job.b1 = st_q.prev0;
						job.c1 = v;
						st_d.position = 2'd0;
					end else begin
						job.a1 = st_q.prev1;
						job.b1 = v;
						job.c1 = st_q.prev0;
						st_d.first_index = st_q.prev0;
						st_d.prev1 = v;
						st_d.position = 2'd2;
					end
				end
			end
			default: begin
				job.num_prims = 2'd0;
			end
		endcase
		st_d.have_first = 1'b1;
		if (last) begin
			st_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (clear) begin
			st_q <= '0;
		end else if (consume) begin
			st_q <= st_d;
		end
	end

endmodule

// ===== rtl/core/pa_emit.sv =====
// result register: holds one job and sends its results one beat at a time
// depends on pa_pkg
module pa_emit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  pa_pkg::job_t job,
	input  logic         ready,
	output logic         valid,
	output logic [1:0]   kind,
	output pa_pkg::idx_t idx_a,
	output pa_pkg::idx_t idx_b,
	output pa_pkg::idx_t idx_c,
	output logic         is_last,
	output logic         free
);

	pa_pkg::job_t job_q;
	logic         valid_q;
	logic         prim_q;
	logic [1:0]   side_q;
	pa_pkg::idx_t ta;
	pa_pkg::idx_t tb;
	pa_pkg::idx_t tc;

	always_comb begin
		ta = prim_q ? job_q.a1 : job_q.a0;
		tb = prim_q ? job_q.b1 : job_q.b0;
		tc = prim_q ? job_q.c1 : job_q.c0;
		if (job_q.wireframe) begin
			kind = pa_pkg::KIND_LINE;
			idx_c = '0;
			case (side_q)
				2'd0: begin
					idx_a = ta;
					idx_b = tb;
				end
				2'd1: begin
					idx_a = tb;
					idx_b = tc;
				end
				default: begin
					idx_a = tc;
					idx_b = ta;
				end
			endcase
		end else begin
			kind = job_q.kind;
			idx_a = ta;
			idx_b = tb;
			idx_c = tc;
		end
		is_last = (prim_q == (job_q.num_prims == 2'd2))
			&& (!job_q.wireframe || side_q == 2'd2);
	end

	assign valid = valid_q;
	assign free  = !valid_q || (ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			prim_q  <= 1'b0;
			side_q  <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			prim_q  <= 1'b0;
			side_q  <= 2'd0;
		end else if (valid_q && ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else if (job_q.wireframe && side_q != 2'd2) begin
				side_q <= side_q + 2'd1;
			end else begin
				side_q <= 2'd0;
				prim_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
	end

endmodule

// ===== rtl/core/primitive_assembler.sv =====
// top level of the primitive assembler: input register, configuration, decode and result stage
// depends on pa_pkg, pa_decode and pa_emit
//
// Turns a stream of vertex indices into point, line and triangle index tuples
// following the usual primitive modes (points, lines, line strip, line loop,
// triangles, triangle strip, fan, polygon, quads, quad strip). Each accepted
// vertex beat is held in the input register, is decoded against the set
// state, and its primitives move to a result register that sends one result
// beat per cycle while m_tready is high. Each result of a vertex leaves as a
// beat of its own: none or one in most modes, two for quads, quad strips
// and the closing vertex of a line loop, and in wireframe mode
// (triangles_as_faces = 0) three lines per triangle, so up to six lines per
// vertex. Vertices that give no result pass at one per cycle. While a vertex's
// results drain, the input register takes the next vertex and holds it there
// if it has results of its own; tlast on the output marks the final result of
// a vertex. A write of primitive_mode drops the set in progress; configuration
// is to be written only while the block is idle.
module primitive_assembler (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [3:0]   cfg_data,
	// vertex input
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // vertex_index
	input  logic         s_tlast,   // last_vertex
	// result output
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // index_a, index_b, index_c
	output logic [1:0]   m_tuser,   // prim_kind
	output logic         m_tlast    // last_result
);

	// configuration registers
	logic [3:0]   mode_q;
	logic         faces_q;
	logic         cfg_we;
	logic         mode_clear;

	// input register
	logic         valid_s1;
	pa_pkg::idx_t vertex_s1;
	logic         last_s1;

	// decode and result stage
	pa_pkg::job_t job;
	logic         consume;
	logic         load;
	logic         emit_free;
	pa_pkg::idx_t idx_a;
	pa_pkg::idx_t idx_b;
	pa_pkg::idx_t idx_c;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign mode_clear = cfg_we && cfg_index == pa_pkg::CFG_PRIMITIVE_MODE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= pa_pkg::MODE_TRIANGLES;
			faces_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				pa_pkg::CFG_PRIMITIVE_MODE:     mode_q  <= cfg_data;
				pa_pkg::CFG_TRIANGLES_AS_FACES: faces_q <= cfg_data[0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// the input register moves on once the result register can take its job,
	// at once when the vertex makes no result
	assign consume  = valid_s1 && (emit_free || job.num_prims == 2'd0);
	assign load     = consume && job.num_prims != 2'd0;
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			vertex_s1 <= s_tdata[pa_pkg::INDEX_WIDTH-1:0];
			last_s1   <= s_tlast;
		end
	end

	pa_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.faces   (faces_q),
		.v       (vertex_s1),
		.last    (last_s1),
		.consume (consume),
		.clear   (mode_clear),
		.job     (job)
	);

	pa_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.job     (job),
		.ready   (m_tready),
		.valid   (m_tvalid),
		.kind    (m_tuser),
		.idx_a   (idx_a),
		.idx_b   (idx_b),
		.idx_c   (idx_c),
		.is_last (m_tlast),
		.free    (emit_free)
	);

	// indexes zero-extended to the 32-bit fields
	assign m_tdata = {32'(idx_c), 32'(idx_b), 32'(idx_a)};

	// an empty input register always takes a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	// the final beat of a job empties the result register unless a new job loads
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid)
		else $error("result register still valid after final beat");

	// lines and points never carry a third index
	a_no_third_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != pa_pkg::KIND_TRI) |-> m_tdata[95:64] == 32'd0)
		else $error("third index set on a point or line");

	// a result beat held by backpressure does not lose the job
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for primitive_assembler: directed mode tests, then random primitive sets
// depends on pa_pkg and the primitive_assembler rtl; keeps its own assembly model in step with the dut
module tb;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;      // input register, decode and result stage
	localparam int unsigned RANDOM_ITEMS = 180;

	// one expected result beat
	typedef struct {
		logic [1:0]   kind;
		pa_pkg::idx_t a;
		pa_pkg::idx_t b;
		pa_pkg::idx_t c;
		logic         last;
	} prim_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [3:0]   cfg_index = '0;
	logic [3:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;    // vertex_index
	logic         s_tlast = 1'b0;  // last_vertex
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [95:0]  m_tdata;         // index_a, index_b, index_c
	logic [1:0]   m_tuser;         // prim_kind
	logic         m_tlast;         // last_result

	primitive_assembler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// configuration and set state as the assembler should hold them
	logic [3:0]   cur_mode = pa_pkg::MODE_TRIANGLES;
	logic         cur_faces = 1'b1;
	pa_pkg::idx_t asm_first = '0;
	pa_pkg::idx_t asm_prev0 = '0;
	pa_pkg::idx_t asm_prev1 = '0;
	logic [1:0]   asm_pos = '0;
	logic         asm_parity = 1'b0;
	logic         asm_started = 1'b0;

	prim_t       step_prims[$];     // primitives made by the vertex being assembled
	prim_t       pending_prims[$];  // primitives still to come out of the dut
	int unsigned mismatches = 0;

	// idle odds per side: 0 means never idle, n means an idle burst starts with odds of about 1 in n
	int unsigned src_odds = 0;
	int unsigned sink_odds = 0;
	int unsigned sink_hold = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_set();
		asm_first   = '0;
		asm_prev0   = '0;
		asm_prev1   = '0;
		asm_pos     = '0;
		asm_parity  = 1'b0;
		asm_started = 1'b0;
	endfunction

	function automatic void emit(input logic [1:0] kind, input pa_pkg::idx_t a,
			input pa_pkg::idx_t b, input pa_pkg::idx_t c);
		prim_t p;
		p.kind = kind;
		p.a = a;
		p.b = b;
		p.c = c;
		p.last = 1'b0;
		step_prims.insert(step_prims.size(), p);
	endfunction

	// a triangle is a face, or its three sides as lines in wireframe
	function automatic void emit_tri(input pa_pkg::idx_t a, input pa_pkg::idx_t b,
			input pa_pkg::idx_t c);
		if (cur_faces) begin
			emit(pa_pkg::KIND_TRI, a, b, c);
		end else begin
			emit(pa_pkg::KIND_LINE, a, b, '0);
			emit(pa_pkg::KIND_LINE, b, c, '0);
			emit(pa_pkg::KIND_LINE, c, a, '0);
		end
	endfunction

	// advance the set state by one accepted vertex and queue the primitives it completes
	function automatic void assemble_vertex(input logic [31:0] vin, input logic last);
		pa_pkg::idx_t v;
		v = pa_pkg::idx_t'(vin);
		step_prims.delete();
		case (cur_mode)
			pa_pkg::MODE_POINTS: emit(pa_pkg::KIND_POINT, v, '0, '0);
			pa_pkg::MODE_LINES: begin
				if (asm_pos == 2'd0) begin
					asm_prev0 = v;
					asm_pos = 2'd1;
				end else begin
					emit(pa_pkg::KIND_LINE, asm_prev0, v, '0);
					asm_pos = 2'd0;
				end
			end
			pa_pkg::MODE_LINE_STRIP, pa_pkg::MODE_LINE_LOOP: begin
				if (asm_started) begin
					emit(pa_pkg::KIND_LINE, asm_prev0, v, '0);
					// the loop closes from the last index back to the first
					if (cur_mode == pa_pkg::MODE_LINE_LOOP && last)
						emit(pa_pkg::KIND_LINE, v, asm_first, '0);
				end else begin
					asm_first = v;
				end
				asm_prev0 = v;
			end
			pa_pkg::MODE_TRIANGLES: begin
				if (asm_pos == 2'd0) begin
					asm_first = v;
					asm_pos = 2'd1;
				end else if (asm_pos == 2'd1) begin
					asm_prev0 = v;
					asm_pos = 2'd2;
				end else begin
					emit_tri(asm_first, asm_prev0, v);
					asm_pos = 2'd0;
				end
			end
			pa_pkg::MODE_TRI_STRIP: begin
				// odd strip triangles swap the last two corners to keep the winding
				if (asm_pos >= 2'd2) begin
					if (asm_parity)
						emit_tri(asm_prev1, v, asm_prev0);
					else
						emit_tri(asm_prev1, asm_prev0, v);
				end else begin
					asm_pos = asm_pos + 2'd1;
				end
				asm_prev1 = asm_prev0;
				asm_prev0 = v;
				asm_parity = ~asm_parity;
			end
			pa_pkg::MODE_TRI_FAN, pa_pkg::MODE_POLYGON: begin
				if (asm_pos == 2'd0) begin
					asm_first = v;
					asm_pos = 2'd1;
				end else begin
					if (asm_pos >= 2'd2)
						emit_tri(asm_first, asm_prev0, v);
					else
						asm_pos = 2'd2;
					asm_prev0 = v;
				end
			end
			pa_pkg::MODE_QUADS, pa_pkg::MODE_QUAD_STRIP: begin
				case (asm_pos)
					2'd0: begin
						asm_first = v;
						asm_pos = 2'd1;
					end
					2'd1: begin
						asm_prev1 = v;
						asm_pos = 2'd2;
					end
					2'd2: begin
						asm_prev0 = v;
						asm_pos = 2'd3;
					end
					default: begin
						emit_tri(asm_first, asm_prev1, asm_prev0);
						if (cur_mode == pa_pkg::MODE_QUADS) begin
							emit_tri(asm_first, asm_prev0, v);
							asm_pos = 2'd0;
						end else begin
							// the far edge of this quad starts the next one
							emit_tri(asm_prev1, v, asm_prev0);
							asm_first = asm_prev0;
							asm_prev1 = v;
							asm_pos = 2'd2;
						end
					end
				endcase
			end
			default: ;  // unused mode codes swallow the vertex
		endcase
		asm_started = 1'b1;
		if (last)
			restart_set();
		if (step_prims.size() != 0)
			step_prims[step_prims.size() - 1].last = 1'b1;
		foreach (step_prims[i])
			pending_prims.insert(pending_prims.size(), step_prims[i]);
	endfunction

	// result side: random stall bursts
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= (sink_hold == 1);
		end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
			sink_hold <= $urandom_range(1, 11);
			m_tready <= 1'b0;
		end
	end

	// every result beat is compared against the oldest expected primitive
	always @(posedge clk) begin : check_results
		prim_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_prims.size() == 0) begin
				$error("unexpected result beat: kind %0d a %h b %h c %h", m_tuser,
					m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
				mismatches++;
			end else begin
				want = pending_prims.pop_front();
				if (m_tuser !== want.kind) begin
					$error("prim_kind: expected %0d, got %0d", want.kind, m_tuser);
					mismatches++;
				end
				if (m_tdata[31:0] !== 32'(want.a)) begin
					$error("index_a: expected %h, got %h", want.a, m_tdata[31:0]);
					mismatches++;
				end
				if (m_tdata[63:32] !== 32'(want.b)) begin
					$error("index_b: expected %h, got %h", want.b, m_tdata[63:32]);
					mismatches++;
				end
				if (m_tdata[95:64] !== 32'(want.c)) begin
					$error("index_c: expected %h, got %h", want.c, m_tdata[95:64]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_result: expected %0d, got %0d", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// one vertex beat, after an optional idle burst; tvalid stays up for a following beat
	task automatic send_vertex(input logic [31:0] v, input logic last);
		if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		assemble_vertex(v, last);
	endtask

	// let every expected result drain, plus vertices still inside that make none
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_prims.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one configuration beat; cfg_valid stays up so back-to-back writes need no gap
	task automatic write_reg(input logic [3:0] idx, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == pa_pkg::CFG_PRIMITIVE_MODE) begin
			cur_mode = val;
			restart_set();
		end else if (idx == pa_pkg::CFG_TRIANGLES_AS_FACES) begin
			cur_faces = val[0];
		end
	endtask

	// mode write abandons any open set; a spare index write must change nothing
	task automatic set_mode(input logic [3:0] mode, input logic faces, input logic spare_write);
		wait_idle();
		if (spare_write)
			write_reg(4'($urandom_range(pa_pkg::CFG_TRIANGLES_AS_FACES + 1, 15)),
				4'($urandom));
		write_reg(pa_pkg::CFG_PRIMITIVE_MODE, mode);
		write_reg(pa_pkg::CFG_TRIANGLES_AS_FACES, {3'($urandom), faces});
		cfg_valid <= 1'b0;
	endtask

	// face mode change in the middle of a set keeps the set going
	task automatic set_faces(input logic faces);
		wait_idle();
		write_reg(pa_pkg::CFG_TRIANGLES_AS_FACES, {3'($urandom), faces});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_index();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return 32'($urandom_range(0, 255));
			default: return 32'($urandom);
		endcase
	endfunction

	// mostly sets that close cleanly for the mode, sometimes any length
	function automatic int unsigned set_length(input logic [3:0] mode);
		int unsigned k;
		k = $urandom_range(1, 4);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 12);
		case (mode)
			pa_pkg::MODE_LINES: return 2 * k;
			pa_pkg::MODE_TRIANGLES: return 3 * k;
			pa_pkg::MODE_QUADS: return 4 * k;
			pa_pkg::MODE_QUAD_STRIP: return 2 * k + 2;
			pa_pkg::MODE_TRI_STRIP, pa_pkg::MODE_TRI_FAN, pa_pkg::MODE_POLYGON:
				return k + 1 + $urandom_range(0, 4);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic send_set(input int unsigned len, input logic close);
		for (int unsigned i = 0; i < len; i++)
			send_vertex(random_index(), close && i == len - 1);
	endtask

	// reset defaults are triangles as faces; the open set is then dropped by a mode write
	task automatic test_triangle_modes();
		send_set(4, 1'b0);
		set_mode(pa_pkg::MODE_TRI_STRIP, 1'b1, 1'b0);
		send_set(4, 1'b1);
		set_mode(pa_pkg::MODE_TRI_FAN, 1'b0, 1'b0);
		send_set(3, 1'b1);
		set_mode(pa_pkg::MODE_POLYGON, 1'b1, 1'b0);
		send_set(3, 1'b1);
	endtask

	task automatic test_point_extremes();
		set_mode(pa_pkg::MODE_POINTS, 1'b1, 1'b0);
		send_vertex('0, 1'b0);
		send_vertex('1, 1'b1);
	endtask

	// includes a loop of a single index, which closes nothing
	task automatic test_line_modes();
		set_mode(pa_pkg::MODE_LINES, 1'b1, 1'b0);
		send_set(2, 1'b1);
		set_mode(pa_pkg::MODE_LINE_STRIP, 1'b1, 1'b0);
		send_set(2, 1'b1);
		set_mode(pa_pkg::MODE_LINE_LOOP, 1'b0, 1'b0);
		send_set(1, 1'b1);
		send_set(3, 1'b1);
	endtask

	// wireframe quads give the longest burst: six lines from one vertex
	task automatic test_quad_modes();
		set_mode(pa_pkg::MODE_QUADS, 1'b0, 1'b0);
		send_set(4, 1'b1);
		set_mode(pa_pkg::MODE_QUAD_STRIP, 1'b1, 1'b0);
		send_set(6, 1'b1);
	endtask

	task automatic test_unused_mode();
		set_mode(4'($urandom_range(pa_pkg::MODE_QUAD_STRIP + 1, 15)), 1'b1, 1'b1);
		send_set(1, 1'b1);
	endtask

	task automatic test_random_sets();
		int unsigned sent;
		int unsigned n_sets;
		int unsigned len;
		logic [3:0]  mode;
		logic        open_end;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// last stretch runs with both sides at full rate
			if (sent >= RANDOM_ITEMS * 4 / 5) begin
				src_odds = 0;
				sink_odds = 0;
			end else begin
				src_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
				sink_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
			end
			if ($urandom_range(0, 11) == 0)
				mode = 4'($urandom_range(pa_pkg::MODE_QUAD_STRIP + 1, 15));
			else
				mode = 4'($urandom_range(pa_pkg::MODE_POINTS, pa_pkg::MODE_QUAD_STRIP));
			set_mode(mode, 1'($urandom), $urandom_range(0, 3) == 0);
			n_sets = $urandom_range(1, 4);
			for (int unsigned s = 0; s < n_sets; s++) begin
				len = set_length(mode);
				// now and then the phase ends with a set left open for the next mode write
				open_end = (s == n_sets - 1) && $urandom_range(0, 7) == 0;
				for (int unsigned i = 0; i < len; i++) begin
					if (i == len / 2 && len > 2 && $urandom_range(0, 9) == 0)
						set_faces(1'($urandom));
					send_vertex(random_index(), !open_end && i == len - 1);
					if (mode <= pa_pkg::MODE_QUAD_STRIP)
						sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_odds = 3;
		sink_odds = 3;
		test_triangle_modes();
		test_point_extremes();
		test_line_modes();
		test_quad_modes();
		test_unused_mode();
		test_random_sets();
		wait_idle();
		if (mismatches == 0 && pending_prims.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
